### rtl/core/temp_humidity_frame_decoder_defines.svh
// Assertion macros for the temperature and humidity frame decoder.
// Included by the RTL files that carry concurrent assertions; no dependencies.
`ifndef TEMP_HUMIDITY_FRAME_DECODER_DEFINES_SVH
`define TEMP_HUMIDITY_FRAME_DECODER_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is asserted.
`define THD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define THD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define THD_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define THD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/core/thd_pkg.sv
// Shared constants, types and codes of the temperature and humidity frame decoder.
// No dependencies.
package thd_pkg;

  // CRC-8 as used by the sensor frame: polynomial 0x31, seed 0xFF, MSB first.
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_MSB  = 8'h80;

  // Conversion: value = floor(scale * raw / 65535), less the offset for temperature.
  localparam logic [14:0]        TEMP_SCALE  = 15'd17500;
  localparam logic [13:0]        HUM_SCALE   = 14'd10000;
  localparam logic [16:0]        DIV_BASE    = 17'd65535;
  localparam logic signed [15:0] TEMP_OFFSET = 16'sd4500;

  // Byte positions within a six-byte frame.
  localparam logic [2:0] POS_T_HI  = 3'd0;
  localparam logic [2:0] POS_T_LO  = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_HI  = 3'd3;
  localparam logic [2:0] POS_H_LO  = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TEMP_ERR = 2'd1,
    ST_HUM_ERR  = 2'd2
  } status_t;

  // Load strobes for the scaler's product registers.
  typedef struct packed {
    logic load_t;
    logic load_h;
  } scale_ctl_t;

endpackage

### rtl/core/temp_humidity_frame_decoder.sv
// Temperature and humidity frame decoder: input register, frame tracking,
// CRC check and result register. Depends on thd_pkg, thd_crc8, thd_scaler
// and temp_humidity_frame_decoder_defines.svh.
//
// Usage: frame bytes enter on the in_ channel (valid/ready), one per
// transaction, in wire order: temperature high, low, CRC, humidity high,
// low, CRC. in_frame_start marks the first byte of a frame and restarts
// the frame; without it the byte position wraps after the sixth byte.
// Each sixth byte yields one transaction on the out_ channel carrying the
// temperature and humidity in hundredths and a status (ok, temperature
// CRC error, humidity CRC error); the values are zero on error.
// Throughput: one byte per cycle while the result side is not stalled. A
// byte is held in the input register and its result is then registered in
// the result register. The conversion products are registered when each low
// byte passes, so the sixth byte only adds and compares.
// Reset (rst_n low, synchronous) empties both registers and returns the
// frame position to the first byte. When the receiver stalls, the result
// is held; further bytes that produce no result keep flowing, and a byte
// that completes a frame waits in the input register, dropping in_ready.
`include "temp_humidity_frame_decoder_defines.svh"
module temp_humidity_frame_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  input  logic               in_frame_start,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [14:0] out_temperature_centi,
  output logic [13:0]        out_humidity_centi,
  output logic [1:0]         out_frame_status
);

  logic                 s1_valid_r;
  logic [7:0]           s1_byte_r;
  logic                 s1_start_r;

  logic [2:0]           pos_r, pos_nxt, pos_eff;
  logic [7:0]           crc_r, crc_nxt, crc_seed, crc_upd;
  logic [15:0]          temp_word_r, temp_word_nxt;
  logic [15:0]          hum_word_r, hum_word_nxt;
  logic                 temp_ok_r, temp_ok_nxt;

  logic                 out_valid_r;
  logic signed [14:0]   out_temp_r;
  logic [13:0]          out_hum_r;
  thd_pkg::status_t     out_status_r, status_nxt;

  logic                 has_result, out_space, s1_go, hum_ok;
  thd_pkg::scale_ctl_t  scale_ctl;
  logic signed [14:0]   temp_conv;
  logic [13:0]          hum_conv;

  // A frame start, or an out-of-range position, restarts at the first byte.
  always_comb begin
    if (s1_start_r || (pos_r > thd_pkg::POS_H_CRC)) begin
      pos_eff = thd_pkg::POS_T_HI;
    end else begin
      pos_eff = pos_r;
    end
  end

  assign crc_seed = ((pos_eff == thd_pkg::POS_T_HI) || (pos_eff == thd_pkg::POS_H_HI)) ?
                    thd_pkg::CRC_INIT : crc_r;

  thd_crc8 u_crc (
    .crc_in  (crc_seed),
    .data    (s1_byte_r),
    .crc_out (crc_upd)
  );

  assign has_result = (pos_eff == thd_pkg::POS_H_CRC);
  assign out_space  = !out_valid_r || out_ready;
  assign s1_go      = s1_valid_r && (!has_result || out_space);
  assign in_ready   = !s1_valid_r || s1_go;
  assign hum_ok     = (crc_r == s1_byte_r);

  always_comb begin
    temp_word_nxt = temp_word_r;
    hum_word_nxt  = hum_word_r;
    if (pos_eff == thd_pkg::POS_T_HI) begin
      temp_word_nxt = {s1_byte_r, 8'h00};
    end else if (pos_eff == thd_pkg::POS_T_LO) begin
      temp_word_nxt = {temp_word_r[15:8], s1_byte_r};
    end
    if (pos_eff == thd_pkg::POS_H_HI) begin
      hum_word_nxt = {s1_byte_r, 8'h00};
    end else if (pos_eff == thd_pkg::POS_H_LO) begin
      hum_word_nxt = {hum_word_r[15:8], s1_byte_r};
    end
  end

  assign scale_ctl.load_t = s1_go && (pos_eff == thd_pkg::POS_T_LO);
  assign scale_ctl.load_h = s1_go && (pos_eff == thd_pkg::POS_H_LO);

  thd_scaler u_scaler (
    .clk        (clk),
    .ctl        (scale_ctl),
    .temp_word  (temp_word_nxt),
    .hum_word   (hum_word_nxt),
    .temp_centi (temp_conv),
    .hum_centi  (hum_conv)
  );

  always_comb begin
    pos_nxt     = pos_r;
    crc_nxt     = crc_r;
    temp_ok_nxt = temp_ok_r;
    if (s1_go) begin
      unique case (pos_eff)
        thd_pkg::POS_T_HI: begin
          crc_nxt = crc_upd;
          pos_nxt = thd_pkg::POS_T_LO;
        end
        thd_pkg::POS_T_LO: begin
          crc_nxt = crc_upd;
          pos_nxt = thd_pkg::POS_T_CRC;
        end
        thd_pkg::POS_T_CRC: begin
          temp_ok_nxt = (crc_r == s1_byte_r);
          crc_nxt     = thd_pkg::CRC_INIT;
          pos_nxt     = thd_pkg::POS_H_HI;
        end
        thd_pkg::POS_H_HI: begin
          crc_nxt = crc_upd;
          pos_nxt = thd_pkg::POS_H_LO;
        end
        thd_pkg::POS_H_LO: begin
          crc_nxt = crc_upd;
          pos_nxt = thd_pkg::POS_H_CRC;
        end
        default: begin
          crc_nxt = thd_pkg::CRC_INIT;
          pos_nxt = thd_pkg::POS_T_HI;
        end
      endcase
    end
  end

  always_comb begin
    if (!temp_ok_r) begin
      status_nxt = thd_pkg::ST_TEMP_ERR;
    end else if (!hum_ok) begin
      status_nxt = thd_pkg::ST_HUM_ERR;
    end else begin
      status_nxt = thd_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      pos_r       <= thd_pkg::POS_T_HI;
      crc_r       <= thd_pkg::CRC_INIT;
      temp_word_r <= 16'h0000;
      hum_word_r  <= 16'h0000;
      temp_ok_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_go) begin
        pos_r       <= pos_nxt;
        crc_r       <= crc_nxt;
        temp_word_r <= temp_word_nxt;
        hum_word_r  <= hum_word_nxt;
        temp_ok_r   <= temp_ok_nxt;
      end
      if (s1_go && has_result) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r  <= in_rx_byte;
      s1_start_r <= in_frame_start;
    end
    if (s1_go && has_result) begin
      out_status_r <= status_nxt;
      if (status_nxt == thd_pkg::ST_OK) begin
        out_temp_r <= temp_conv;
        out_hum_r  <= hum_conv;
      end else begin
        out_temp_r <= 15'sd0;
        out_hum_r  <= 14'd0;
      end
    end
  end

  assign out_valid             = out_valid_r;
  assign out_temperature_centi = out_temp_r;
  assign out_humidity_centi    = out_hum_r;
  assign out_frame_status      = out_status_r;

  `THD_ASSERT_IMPLY(a_pos_range, clk, rst_n, 1'b1, pos_r <= thd_pkg::POS_H_CRC)
  `THD_ASSERT_IMPLY(a_err_zero, clk, rst_n, out_valid_r && (out_status_r != thd_pkg::ST_OK), (out_temp_r == 15'sd0) && (out_hum_r == 14'd0))
  `THD_ASSERT_NEXT(a_result_loaded, clk, rst_n, s1_go && has_result, out_valid_r)
  `THD_ASSERT_IMPLY(a_stall_cause, clk, rst_n, !in_ready, s1_valid_r && has_result && out_valid_r && !out_ready)

endmodule

### rtl/core/thd_crc8.sv
// One-byte CRC-8 update, eight MSB-first shift steps unrolled.
// Depends on thd_pkg for the polynomial.
module thd_crc8 (
  input  logic [7:0] crc_in,
  input  logic [7:0] data,
  output logic [7:0] crc_out
);

  always_comb begin
    logic [7:0] c;
    c = crc_in ^ data;
    for (int k = 0; k < 8; k++) begin
      if ((c & thd_pkg::CRC_MSB) != 8'h00) begin
        c = {c[6:0], 1'b0} ^ thd_pkg::CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

### rtl/core/thd_scaler.sv
// Raw-word to centi-unit conversion for temperature and humidity.
// Depends on thd_pkg for the scale constants and the control struct.
module thd_scaler (
  input  logic                 clk,
  input  thd_pkg::scale_ctl_t  ctl,
  input  logic [15:0]          temp_word,
  input  logic [15:0]          hum_word,
  output logic signed [14:0]   temp_centi,
  output logic [13:0]          hum_centi
);

  logic [30:0]        prod_t_r;
  logic [29:0]        prod_h_r;
  logic [14:0]        t_hi;
  logic [15:0]        t_lo;
  logic [16:0]        t_sum;
  logic [14:0]        t_q;
  logic signed [15:0] t_val;
  logic [13:0]        h_hi;
  logic [15:0]        h_lo;
  logic [16:0]        h_sum;

  // Products are taken when the low byte of each word arrives.
  always_ff @(posedge clk) begin
    if (ctl.load_t) begin
      prod_t_r <= 31'(temp_word) * 31'(thd_pkg::TEMP_SCALE);
    end
    if (ctl.load_h) begin
      prod_h_r <= 30'(hum_word) * 30'(thd_pkg::HUM_SCALE);
    end
  end

  // x = hi*65536 + lo = hi*65535 + (hi + lo), and hi + lo stays below
  // twice 65535, so a single compare corrects the quotient.
  always_comb begin
    t_hi  = prod_t_r[30:16];
    t_lo  = prod_t_r[15:0];
    t_sum = 17'(t_hi) + 17'(t_lo);
    t_q   = t_hi + 15'(t_sum >= thd_pkg::DIV_BASE);
    t_val = $signed({1'b0, t_q}) - thd_pkg::TEMP_OFFSET;
    temp_centi = t_val[14:0];

    h_hi  = prod_h_r[29:16];
    h_lo  = prod_h_r[15:0];
    h_sum = 17'(h_hi) + 17'(h_lo);
    hum_centi = h_hi + 14'(h_sum >= thd_pkg::DIV_BASE);
  end

endmodule

### tb/temp_humidity_frame_decoder_tb.sv
// Self-checking testbench for temp_humidity_frame_decoder: six-byte frames with CRC-8
// checks and centi-unit conversion, predicted per byte and compared per result.
// Depends on thd_pkg and the decoder RTL.
module temp_humidity_frame_decoder_tb;

  localparam int CLK_HALF    = 4;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 400;
  localparam int END_CYCLES  = 10;

  typedef struct {
    logic signed [14:0] temp_centi;
    logic [13:0]        hum_centi;
    thd_pkg::status_t   status;
  } reading_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_rx_byte = 8'h00;
  logic               in_frame_start = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [14:0] out_temperature_centi;
  logic [13:0]        out_humidity_centi;
  logic [1:0]         out_frame_status;

  // Predictor state, mirroring the decoder's frame tracking.
  logic [2:0]  frame_pos = thd_pkg::POS_T_HI;
  logic [7:0]  crc_acc = thd_pkg::CRC_INIT;
  logic [15:0] temp_raw = 16'h0000;
  logic [15:0] hum_raw = 16'h0000;
  logic        temp_good = 1'b0;

  reading_t pending_readings[$];
  bit       idle_enable = 1'b1;
  int       hold_left = 0;
  int       bytes_sent = 0;
  int       readings_checked = 0;
  int       error_count = 0;
  int       quiet_cycles = 0;

  temp_humidity_frame_decoder dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_rx_byte            (in_rx_byte),
    .in_frame_start        (in_frame_start),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_temperature_centi (out_temperature_centi),
    .out_humidity_centi    (out_humidity_centi),
    .out_frame_status      (out_frame_status)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] acc;
    acc = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if ((acc & thd_pkg::CRC_MSB) != 8'h00) acc = (acc << 1) ^ thd_pkg::CRC_POLY;
      else acc = acc << 1;
    end
    return acc;
  endfunction

  function automatic logic [7:0] word_crc(input logic [15:0] word);
    return crc8_update(crc8_update(thd_pkg::CRC_INIT, word[15:8]), word[7:0]);
  endfunction

  // Advances the frame model by one accepted byte; the sixth byte queues a reading.
  function automatic void decode_byte(input logic [7:0] b, input logic fs);
    logic [2:0]  pos;
    reading_t    r;
    int          t_val;
    int unsigned h_val;
    if (fs) begin
      frame_pos = thd_pkg::POS_T_HI;
      crc_acc   = thd_pkg::CRC_INIT;
    end
    pos = (frame_pos > thd_pkg::POS_H_CRC) ? thd_pkg::POS_T_HI : frame_pos;
    case (pos)
      thd_pkg::POS_T_HI: begin
        crc_acc  = crc8_update(thd_pkg::CRC_INIT, b);
        temp_raw = {b, 8'h00};
      end
      thd_pkg::POS_T_LO: begin
        crc_acc       = crc8_update(crc_acc, b);
        temp_raw[7:0] = b;
      end
      thd_pkg::POS_T_CRC: begin
        temp_good = (crc_acc == b);
        crc_acc   = thd_pkg::CRC_INIT;
      end
      thd_pkg::POS_H_HI: begin
        crc_acc = crc8_update(thd_pkg::CRC_INIT, b);
        hum_raw = {b, 8'h00};
      end
      thd_pkg::POS_H_LO: begin
        crc_acc      = crc8_update(crc_acc, b);
        hum_raw[7:0] = b;
      end
      default: begin
        r.temp_centi = '0;
        r.hum_centi  = '0;
        if (!temp_good) begin
          r.status = thd_pkg::ST_TEMP_ERR;
        end else if (crc_acc != b) begin
          r.status = thd_pkg::ST_HUM_ERR;
        end else begin
          t_val        = -4500 + int'((17500 * int'(temp_raw)) / 65535);
          h_val        = (10000 * int'(hum_raw)) / 65535;
          r.status     = thd_pkg::ST_OK;
          r.temp_centi = t_val[14:0];
          r.hum_centi  = h_val[13:0];
        end
        crc_acc   = thd_pkg::CRC_INIT;
        frame_pos = thd_pkg::POS_T_HI;
        pending_readings.push_back(r);
        return;
      end
    endcase
    frame_pos = pos + 3'd1;
  endfunction

  // Offers one byte and returns right after the edge at which it was accepted.
  task automatic send_byte(input logic [7:0] b, input logic fs);
    while (idle_enable && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_rx_byte     <= b;
    in_frame_start <= fs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_byte(b, fs);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [15:0] t_word, input logic [15:0] h_word,
                            input bit t_bad, input bit h_bad, input logic fs);
    logic [7:0] t_crc;
    logic [7:0] h_crc;
    t_crc = word_crc(t_word) ^ (t_bad ? 8'($urandom_range(255, 1)) : 8'h00);
    h_crc = word_crc(h_word) ^ (h_bad ? 8'($urandom_range(255, 1)) : 8'h00);
    send_byte(t_word[15:8], fs);
    send_byte(t_word[7:0], 1'b0);
    send_byte(t_crc, 1'b0);
    send_byte(h_word[15:8], 1'b0);
    send_byte(h_word[7:0], 1'b0);
    send_byte(h_crc, 1'b0);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(255));
      3: return 16'hFFFF - 16'($urandom_range(255));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_frame();
    int pick;
    pick = $urandom_range(9);
    send_frame(pick_word(), pick_word(), pick == 0 || pick == 2, pick == 1 || pick == 2,
               $urandom_range(3) != 0);
  endtask

  // Range extremes, a restart in the middle of a frame and a frame without its start mark.
  task automatic test_extremes_restart_wrap();
    send_byte(8'hA5, 1'b1);
    send_byte(8'h5A, 1'b0);
    send_frame(16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b1);
    send_frame(16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b0);
    wait_drain();
  endtask

  // Humidity CRC wrong alone, and both CRCs wrong so the temperature error wins.
  task automatic test_crc_errors();
    send_frame(16'h6666, 16'h8000, 1'b0, 1'b1, 1'b1);
    send_frame(16'h1234, 16'hFEDC, 1'b1, 1'b1, 1'b1);
    wait_drain();
  endtask

  task automatic test_random_frames(input int frames);
    repeat (frames) random_frame();
    wait_drain();
  endtask

  task automatic test_back_to_back(input int frames);
    idle_enable = 1'b0;
    repeat (frames) random_frame();
    wait_drain();
    idle_enable = 1'b1;
  endtask

  // The receiver holds off while frames keep coming, so the decoder must stall its input.
  task automatic test_output_stall(input int frames);
    hold_left = HOLD_CYCLES;
    repeat (frames) random_frame();
    wait_drain();
  endtask

  // Stray bytes, stray start marks and frames broken off part way.
  task automatic test_noise(input int rounds);
    repeat (rounds) begin
      case ($urandom_range(3))
        0: repeat ($urandom_range(6, 1))
             send_byte(8'($urandom), $urandom_range(5) == 0);
        1: begin
          send_byte(8'($urandom), 1'b1);
          repeat ($urandom_range(4)) send_byte(8'($urandom), 1'b0);
        end
        default: random_frame();
      endcase
    end
    wait_drain();
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (!idle_enable) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 33);
    end
  end

  always @(posedge clk) begin : check_readings
    reading_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_readings.size() == 0) begin
        $error("result transaction with no reading pending");
        error_count++;
      end else begin
        want = pending_readings.pop_front();
        readings_checked++;
        if (out_temperature_centi !== want.temp_centi) begin
          $error("temperature_centi: expected %0d, got %0d", want.temp_centi,
                 out_temperature_centi);
          error_count++;
        end
        if (out_humidity_centi !== want.hum_centi) begin
          $error("humidity_centi: expected %0d, got %0d", want.hum_centi,
                 out_humidity_centi);
          error_count++;
        end
        if (out_frame_status !== want.status) begin
          $error("frame_status: expected %0d, got %0d", want.status, out_frame_status);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_extremes_restart_wrap();
    test_crc_errors();
    test_random_frames(170);
    test_back_to_back(50);
    test_output_stall(30);
    test_noise(90);
    repeat (END_CYCLES) @(posedge clk);
    if (pending_readings.size() != 0) begin
      $error("%0d readings never arrived", pending_readings.size());
      error_count++;
    end
    $display("Sent %0d bytes and checked %0d readings over good frames, CRC errors,",
             bytes_sent, readings_checked);
    $display("restarts, unmarked frames, noise, back-to-back traffic and output stalls.");
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
